FILE: sv/msl_pkg.sv
// Shared types, constants and helper functions for the multi-joint slew limiter.
// No dependencies; every other file of the block refers to this package by scoped names.

package msl_pkg;

   localparam int JOINT_COUNT_DEF = 29;

   localparam int ANGLE_W = 24;
   localparam int GAIN_W  = 16;

   // Depth of the request queue between the front end and the joint engine.
   localparam int CMDQ_DEPTH = 4;

   // Slew rates in rad/s, Q8.8.
   localparam logic [GAIN_W-1:0] SLEW_FLOOR = 16'd3;
   localparam logic [GAIN_W-1:0] SLEW_SLOW  = 16'd512;
   localparam logic [GAIN_W-1:0] SLEW_MID   = 16'd1024;
   localparam logic [GAIN_W-1:0] SLEW_FAST  = 16'd1536;

   // Joint groups for the power-up slew rates.
   localparam logic [7:0] SLOW_LAST    = 8'd14;
   localparam logic [7:0] FAST_A_FIRST = 8'd19;
   localparam logic [7:0] FAST_A_LAST  = 8'd21;
   localparam logic [7:0] FAST_B_FIRST = 8'd26;
   localparam logic [7:0] FAST_B_LAST  = 8'd28;

   // Register map: word index of each control register.
   localparam int CSR_DAMPING = 0;

   // Opcodes as they arrive on the request port.
   typedef enum logic [2:0] {
      OPC_MEASURE = 3'd0,
      OPC_COMMAND = 3'd1,
      OPC_TICK    = 3'd2,
      OPC_READ    = 3'd3,
      OPC_SLEW    = 3'd4,
      OPC_CLEAR   = 3'd5
   } opcode_type;

   // Work the engine carries out after classification.
   typedef enum logic [2:0] {
      ACT_READ,
      ACT_MEASURE,
      ACT_COMMAND,
      ACT_TICK,
      ACT_SLEW,
      ACT_CLEAR
   } action_type;

   typedef struct packed {
      action_type                act;
      logic                      ok;
      logic [7:0]                joint;
      logic signed [ANGLE_W-1:0] position;
      logic [GAIN_W-1:0]         kp;
      logic [GAIN_W-1:0]         kd;
      logic signed [GAIN_W-1:0]  tau;
      logic [GAIN_W-1:0]         rate;
      logic [GAIN_W-1:0]         dt;
      logic                      estop;
   } cmd_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] cmd;
      logic signed [ANGLE_W-1:0] goal;
      logic signed [ANGLE_W-1:0] meas;
      logic [GAIN_W-1:0]         kp;
      logic [GAIN_W-1:0]         kd;
      logic signed [GAIN_W-1:0]  tau;
      logic [GAIN_W-1:0]         slew;
   } row_type;

   typedef struct packed {
      logic                      joint_on;
      logic signed [ANGLE_W-1:0] position_cmd;
      logic signed [ANGLE_W-1:0] position_goal;
      logic [GAIN_W-1:0]         drive_kp;
      logic [GAIN_W-1:0]         drive_kd;
      logic signed [GAIN_W-1:0]  drive_tau;
      logic [GAIN_W-1:0]         stored_kp;
      logic [GAIN_W-1:0]         stored_kd;
      logic                      estop_now;
      logic                      bad_index;
   } res_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_SWEEP,
      ENG_DRAIN,
      ENG_FETCH,
      ENG_SEND
   } eng_state_type;

   // Power-up slew rate of a joint, by joint group.
   function automatic logic [GAIN_W-1:0] default_slew(input logic [7:0] j);
      logic [GAIN_W-1:0] r;
      if (j <= SLOW_LAST) begin
         r = SLEW_SLOW;
      end else if ((j >= FAST_A_FIRST && j <= FAST_A_LAST) ||
                   (j >= FAST_B_FIRST && j <= FAST_B_LAST)) begin
         r = SLEW_FAST;
      end else begin
         r = SLEW_MID;
      end
      return r;
   endfunction

endpackage

FILE: sv/msl_front.sv
// Front end of the slew limiter: takes requests, range-checks the joint index,
// floors the slew rate and hands classified work to the request queue. Uses msl_pkg.

module msl_front #(
   parameter int JOINT_COUNT = msl_pkg::JOINT_COUNT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [2:0]                            req_opcode,
   input  logic [7:0]                            req_joint,
   input  logic signed [msl_pkg::ANGLE_W-1:0]    req_position,
   input  logic [msl_pkg::GAIN_W-1:0]            req_stiffness,
   input  logic [msl_pkg::GAIN_W-1:0]            req_damping,
   input  logic signed [msl_pkg::GAIN_W-1:0]     req_torque,
   input  logic [msl_pkg::GAIN_W-1:0]            req_rate,
   input  logic [msl_pkg::GAIN_W-1:0]            req_tick_time,
   input  logic                                  req_estop,
   input  logic                                  q_full,
   output logic                                  q_push,
   output msl_pkg::cmd_type                      q_data
);

   logic             front_vld_ff, front_vld_in;
   msl_pkg::cmd_type front_ff, front_in;
   msl_pkg::cmd_type dec;
   logic             accept;

   // Classify the incoming request.
   always_comb begin
      dec          = '0;
      dec.ok       = ({1'b0, req_joint} < 9'(JOINT_COUNT));
      dec.joint    = dec.ok ? req_joint : 8'd0;
      dec.position = req_position;
      dec.kp       = req_stiffness;
      dec.kd       = req_damping;
      dec.tau      = req_torque;
      dec.rate     = (req_rate < msl_pkg::SLEW_FLOOR) ? msl_pkg::SLEW_FLOOR : req_rate;
      dec.dt       = req_tick_time;
      dec.estop    = req_estop;
      case (req_opcode)
         msl_pkg::OPC_MEASURE: begin
            dec.act = dec.ok ? msl_pkg::ACT_MEASURE : msl_pkg::ACT_READ;
         end
         msl_pkg::OPC_COMMAND: begin
            dec.act = dec.ok ? msl_pkg::ACT_COMMAND : msl_pkg::ACT_READ;
         end
         msl_pkg::OPC_SLEW: begin
            dec.act = dec.ok ? msl_pkg::ACT_SLEW : msl_pkg::ACT_READ;
         end
         msl_pkg::OPC_TICK: begin
            dec.act = msl_pkg::ACT_TICK;
         end
         msl_pkg::OPC_CLEAR: begin
            dec.act = msl_pkg::ACT_CLEAR;
         end
         default: begin
            dec.act = msl_pkg::ACT_READ;
         end
      endcase
   end

   assign req_full = front_vld_ff & q_full;
   assign accept   = req_push & ~req_full;
   assign q_push   = front_vld_ff & ~q_full;
   assign q_data   = front_ff;

   always_comb begin
      front_in     = front_ff;
      front_vld_in = front_vld_ff;
      if (accept) begin
         front_in     = dec;
         front_vld_in = 1'b1;
      end else if (q_push) begin
         front_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= 1'b0;
      end else begin
         front_vld_ff <= front_vld_in;
      end
      front_ff <= front_in;
   end

endmodule

FILE: sv/msl_queue.sv
// Short first-in first-out queue of classified requests between front end and engine.
// Uses msl_pkg for the entry type and depth.

module msl_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  msl_pkg::cmd_type din,
   output logic             full,
   input  logic             pop,
   output msl_pkg::cmd_type dout,
   output logic             empty
);

   localparam int PTR_W = (msl_pkg::CMDQ_DEPTH > 1) ? $clog2(msl_pkg::CMDQ_DEPTH) : 1;

   msl_pkg::cmd_type slots_ff [msl_pkg::CMDQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (PTR_W+1)'(msl_pkg::CMDQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign dout    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(msl_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(msl_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

FILE: sv/msl_engine.sv
// Back end of the slew limiter: joint table memory, tick sweep pipeline and result register.
// Uses msl_pkg for entry, row and result types, the state enum and power-up slew rates.

module msl_engine #(
   parameter int JOINT_COUNT = msl_pkg::JOINT_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  msl_pkg::cmd_type           q_data,
   output logic                       q_pop,
   input  logic [msl_pkg::GAIN_W-1:0] damping_gain,
   input  logic                       res_pop,
   output logic                       res_vld,
   output msl_pkg::res_type           res
);

   localparam int IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(JOINT_COUNT - 1);

   msl_pkg::row_type mem [JOINT_COUNT];
   msl_pkg::row_type rd_row_ff;

   msl_pkg::eng_state_type state_ff, state_in;
   msl_pkg::cmd_type cur_ff, cur_in;
   logic                   estop_ff, estop_in;
   logic                   release_ff, release_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [JOINT_COUNT-1:0] live_ff, live_in;
   logic [JOINT_COUNT-1:0] slew_set_ff, slew_set_in;
   logic [JOINT_COUNT-1:0] active_ff, active_in;
   logic [JOINT_COUNT-1:0] meas_ok_ff, meas_ok_in;

   logic                   s1_vld_ff, s1_vld_in;
   logic                   s2_vld_ff, s2_vld_in;
   logic [IDX_W-1:0]       s2_idx_ff, s2_idx_in;
   msl_pkg::row_type       s2_row_ff, s2_row_in;
   logic signed [23:0]     s2_cmd0_ff, s2_cmd0_in;
   logic signed [24:0]     s2_err_ff, s2_err_in;
   logic [23:0]            s2_step_ff, s2_step_in;
   logic                   s2_act_ff, s2_act_in;
   logic                   s2_mv_ff, s2_mv_in;

   logic                   slot_vld_ff, slot_vld_in;
   msl_pkg::res_type       slot_ff, slot_in;

   logic [IDX_W-1:0]       cur_idx;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic                   sweep_issue;
   logic                   sweep_last;
   logic                   slot_load;
   logic                   wr_en;
   msl_pkg::row_type       eff;
   logic                   eff_act, eff_mv;
   logic signed [23:0]     cmd0;
   logic [31:0]            prod;
   logic [24:0]            mag;
   logic                   snap;
   logic signed [24:0]     moved_w;
   msl_pkg::row_type       wr_row;
   msl_pkg::res_type       res_c;

   assign cur_idx    = cur_ff.joint[IDX_W-1:0];
   assign sweep_last = (cur_ff.act == msl_pkg::ACT_TICK) ? (idx_ff == LAST_IDX) : 1'b1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msl_pkg::ENG_IDLE: begin
            if (!q_empty) begin
               if (q_data.act == msl_pkg::ACT_READ || q_data.act == msl_pkg::ACT_CLEAR) begin
                  state_in = msl_pkg::ENG_FETCH;
               end else begin
                  state_in = msl_pkg::ENG_SWEEP;
               end
            end
         end
         msl_pkg::ENG_SWEEP: begin
            if (sweep_last) begin
               state_in = msl_pkg::ENG_DRAIN;
            end
         end
         msl_pkg::ENG_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = msl_pkg::ENG_FETCH;
            end
         end
         msl_pkg::ENG_FETCH: begin
            state_in = msl_pkg::ENG_SEND;
         end
         msl_pkg::ENG_SEND: begin
            if (!slot_vld_ff) begin
               state_in = msl_pkg::ENG_IDLE;
            end
         end
         default: begin
            state_in = msl_pkg::ENG_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      q_pop       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = idx_ff;
      sweep_issue = 1'b0;
      slot_load   = 1'b0;
      case (state_ff)
         msl_pkg::ENG_IDLE: begin
            q_pop = ~q_empty;
         end
         msl_pkg::ENG_SWEEP: begin
            rd_en       = 1'b1;
            sweep_issue = 1'b1;
         end
         msl_pkg::ENG_FETCH: begin
            rd_en   = 1'b1;
            rd_addr = cur_idx;
         end
         msl_pkg::ENG_SEND: begin
            slot_load = ~slot_vld_ff;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // Stage one: the row just read, with never-written fields shown at their reset values.
   always_comb begin
      eff = rd_row_ff;
      if (!live_ff[rd_idx_ff]) begin
         eff.cmd  = '0;
         eff.goal = '0;
         eff.kp   = '0;
         eff.kd   = '0;
         eff.tau  = '0;
      end
      if (!slew_set_ff[rd_idx_ff]) begin
         eff.slew = msl_pkg::default_slew(8'(rd_idx_ff));
      end
      eff_act = active_ff[rd_idx_ff];
      eff_mv  = meas_ok_ff[rd_idx_ff];
      cmd0    = (release_ff && eff_mv) ? eff.meas : eff.cmd;
      prod    = 32'(eff.slew) * 32'(cur_ff.dt);
   end

   assign s1_vld_in  = sweep_issue;
   assign rd_idx_in  = rd_en ? rd_addr : rd_idx_ff;
   assign s2_vld_in  = s1_vld_ff;
   assign s2_idx_in  = rd_idx_ff;
   assign s2_row_in  = eff;
   assign s2_cmd0_in = cmd0;
   assign s2_err_in  = $signed({eff.goal[23], eff.goal}) - $signed({cmd0[23], cmd0});
   assign s2_step_in = prod[31:8];
   assign s2_act_in  = eff_act;
   assign s2_mv_in   = eff_mv;

   // Stage two: apply the operation and write the row back.
   always_comb begin
      mag     = s2_err_ff[24] ? 25'(-s2_err_ff) : 25'(s2_err_ff);
      snap    = (mag <= {1'b0, s2_step_ff});
      moved_w = (s2_err_ff > 0) ?
                ($signed({s2_cmd0_ff[23], s2_cmd0_ff}) + $signed({1'b0, s2_step_ff})) :
                ($signed({s2_cmd0_ff[23], s2_cmd0_ff}) - $signed({1'b0, s2_step_ff}));
      wr_row  = s2_row_ff;
      case (cur_ff.act)
         msl_pkg::ACT_MEASURE: begin
            wr_row.meas = cur_ff.position;
         end
         msl_pkg::ACT_COMMAND: begin
            if (!s2_act_ff) begin
               wr_row.cmd = s2_mv_ff ? s2_row_ff.meas : cur_ff.position;
            end
            wr_row.goal = cur_ff.position;
            wr_row.kp   = cur_ff.kp;
            wr_row.kd   = cur_ff.kd;
            wr_row.tau  = cur_ff.tau;
         end
         msl_pkg::ACT_TICK: begin
            if (s2_act_ff) begin
               if (cur_ff.estop) begin
                  wr_row.cmd = s2_mv_ff ? s2_row_ff.meas : s2_cmd0_ff;
               end else begin
                  wr_row.cmd = snap ? s2_row_ff.goal : moved_w[23:0];
               end
            end
         end
         msl_pkg::ACT_SLEW: begin
            wr_row.slew = cur_ff.rate;
         end
         default: begin
            wr_row = s2_row_ff;
         end
      endcase
   end

   assign wr_en = s2_vld_ff;

   // Control registers and per-joint flags.
   always_comb begin
      cur_in      = cur_ff;
      idx_in      = idx_ff;
      estop_in    = estop_ff;
      release_in  = release_ff;
      live_in     = live_ff;
      slew_set_in = slew_set_ff;
      active_in   = active_ff;
      meas_ok_in  = meas_ok_ff;
      if (q_pop) begin
         cur_in = q_data;
         idx_in = (q_data.act == msl_pkg::ACT_TICK) ? '0 : q_data.joint[IDX_W-1:0];
         if (q_data.act == msl_pkg::ACT_TICK) begin
            estop_in   = q_data.estop;
            release_in = estop_ff & ~q_data.estop;
         end
         if (q_data.act == msl_pkg::ACT_CLEAR) begin
            estop_in  = 1'b0;
            live_in   = '0;
            active_in = '0;
            meas_ok_in = '0;
         end
      end else if (sweep_issue) begin
         idx_in = idx_ff + 1'b1;
      end
      if (wr_en) begin
         live_in[s2_idx_ff]     = 1'b1;
         slew_set_in[s2_idx_ff] = 1'b1;
         if (cur_ff.act == msl_pkg::ACT_MEASURE) begin
            meas_ok_in[s2_idx_ff] = 1'b1;
         end
         if (cur_ff.act == msl_pkg::ACT_COMMAND) begin
            active_in[s2_idx_ff] = 1'b1;
         end
      end
   end

   // Result of the addressed joint, read after the operation has finished.
   always_comb begin
      res_c           = '0;
      res_c.estop_now = estop_ff;
      if (!cur_ff.ok) begin
         res_c.bad_index = 1'b1;
      end else begin
         res_c.joint_on      = eff_act;
         res_c.position_cmd  = eff.cmd;
         res_c.position_goal = eff.goal;
         res_c.stored_kp     = eff.kp;
         res_c.stored_kd     = eff.kd;
         if (eff_act) begin
            if (estop_ff) begin
               res_c.drive_kd = damping_gain;
            end else begin
               res_c.drive_kp  = eff.kp;
               res_c.drive_kd  = eff.kd;
               res_c.drive_tau = eff.tau;
            end
         end
      end
   end

   assign slot_in     = slot_load ? res_c : slot_ff;
   assign slot_vld_in = slot_load | (slot_vld_ff & ~res_pop);
   assign res_vld     = slot_vld_ff;
   assign res         = slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= msl_pkg::ENG_IDLE;
         estop_ff    <= 1'b0;
         release_ff  <= 1'b0;
         live_ff     <= '0;
         slew_set_ff <= '0;
         active_ff   <= '0;
         meas_ok_ff  <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         slot_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         estop_ff    <= estop_in;
         release_ff  <= release_in;
         live_ff     <= live_in;
         slew_set_ff <= slew_set_in;
         active_ff   <= active_in;
         meas_ok_ff  <= meas_ok_in;
         s1_vld_ff   <= s1_vld_in;
         s2_vld_ff   <= s2_vld_in;
         slot_vld_ff <= slot_vld_in;
      end
      cur_ff     <= cur_in;
      idx_ff     <= idx_in;
      rd_idx_ff  <= rd_idx_in;
      s2_idx_ff  <= s2_idx_in;
      s2_row_ff  <= s2_row_in;
      s2_cmd0_ff <= s2_cmd0_in;
      s2_err_ff  <= s2_err_in;
      s2_step_ff <= s2_step_in;
      s2_act_ff  <= s2_act_in;
      s2_mv_ff   <= s2_mv_in;
      slot_ff    <= slot_in;
   end

   // Joint table: one write port for stage two, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s2_idx_ff] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   // A row reaches write-back only after passing through stage one.
   assert property (@(posedge clock) disable iff (reset) s2_vld_ff |-> $past(s1_vld_ff))
      else $error("write-back stage valid without a preceding read");

   // The result read must see every write of the current request.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == msl_pkg::ENG_FETCH |-> !s1_vld_ff && !s2_vld_ff)
      else $error("result fetched while the sweep pipeline still holds rows");

   // Reads and clears never write the joint table.
   assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> (cur_ff.act != msl_pkg::ACT_READ && cur_ff.act != msl_pkg::ACT_CLEAR))
      else $error("table write during a read or clear request");

   // A new request is taken only once the previous one has fully drained.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !s1_vld_ff && !s2_vld_ff)
      else $error("request dequeued while the pipeline is busy");

endmodule

FILE: sv/multi_joint_slew_limiter_top.sv
// Top level of the multi-joint slew limiter: request front end, request queue, joint engine
// and the control register port. Uses msl_pkg, msl_front, msl_queue and msl_engine.

// The block keeps a table of joints and handles one request at a time: store a measurement,
// accept a command, run a tick over every joint, read a joint, set a joint's slew rate, or
// clear all joints; every request returns exactly one response showing the addressed joint
// after the request has taken effect. Requests enter through a one-entry front register and a
// four-entry queue, so the producer keeps pushing while the engine works, and the response
// waits in its own output register, so an unread response does not stop the next request from
// being queued. The joint table has one write port and one registered read port, and its
// access pattern sets the throughput: a tick streams through all JOINT_COUNT entries at one
// entry per cycle through a three-stage read, multiply and write-back pipeline; a measure,
// command or set-slew request sends its one entry through the same pipeline, and a read, a
// clear or an out-of-range measure, command or set-slew request goes straight to the result
// read. No clearing pass runs after reset: per-joint flags make never-written entries read as
// their reset values, and the power-up slew rates come from a constant table, so the block
// takes requests as soon as reset is released. The damping gain register sits at byte address
// 0 of the control port and should only be written while no request is in flight.

module multi_joint_slew_limiter_top #(
   parameter int JOINT_COUNT = msl_pkg::JOINT_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_push,
   output logic                               req_full,
   input  logic [2:0]                         req_opcode,
   input  logic [7:0]                         req_joint,
   input  logic signed [msl_pkg::ANGLE_W-1:0] req_position,
   input  logic [msl_pkg::GAIN_W-1:0]         req_stiffness,
   input  logic [msl_pkg::GAIN_W-1:0]         req_damping,
   input  logic signed [msl_pkg::GAIN_W-1:0]  req_torque,
   input  logic [msl_pkg::GAIN_W-1:0]         req_rate,
   input  logic [msl_pkg::GAIN_W-1:0]         req_tick_time,
   input  logic                               req_estop,

   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic                               rsp_joint_on,
   output logic signed [msl_pkg::ANGLE_W-1:0] rsp_position_cmd,
   output logic signed [msl_pkg::ANGLE_W-1:0] rsp_position_goal,
   output logic [msl_pkg::GAIN_W-1:0]         rsp_drive_kp,
   output logic [msl_pkg::GAIN_W-1:0]         rsp_drive_kd,
   output logic signed [msl_pkg::GAIN_W-1:0]  rsp_drive_tau,
   output logic [msl_pkg::GAIN_W-1:0]         rsp_stored_kp,
   output logic [msl_pkg::GAIN_W-1:0]         rsp_stored_kd,
   output logic                               rsp_estop_now,
   output logic                               rsp_bad_index,

   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [2:0]                         csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   logic                       q_full;
   logic                       q_push;
   msl_pkg::cmd_type           q_in_data;
   logic                       q_empty;
   logic                       q_pop;
   msl_pkg::cmd_type           q_out_data;
   logic                       res_vld;
   msl_pkg::res_type           res;
   logic [msl_pkg::GAIN_W-1:0] damping_ff, damping_in;
   logic                       csr_write;
   logic                       csr_hit;

   // Control register port. Registers are one 32-bit word apart; the low address bits
   // pick a byte within the word and do not change which register is selected.
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == 1'(msl_pkg::CSR_DAMPING));
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign damping_in = (csr_write && csr_hit) ? csr_pwdata[msl_pkg::GAIN_W-1:0] : damping_ff;
   assign csr_prdata = csr_hit ? {16'd0, damping_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff <= '0;
      end else begin
         damping_ff <= damping_in;
      end
   end

   msl_front #(
      .JOINT_COUNT (JOINT_COUNT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_opcode    (req_opcode),
      .req_joint     (req_joint),
      .req_position  (req_position),
      .req_stiffness (req_stiffness),
      .req_damping   (req_damping),
      .req_torque    (req_torque),
      .req_rate      (req_rate),
      .req_tick_time (req_tick_time),
      .req_estop     (req_estop),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_in_data)
   );

   msl_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_in_data),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_out_data),
      .empty (q_empty)
   );

   msl_engine #(
      .JOINT_COUNT (JOINT_COUNT)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_data       (q_out_data),
      .q_pop        (q_pop),
      .damping_gain (damping_ff),
      .res_pop      (rsp_pop),
      .res_vld      (res_vld),
      .res          (res)
   );

   // The response register holds the oldest unread response.
   assign rsp_empty         = ~res_vld;
   assign rsp_joint_on      = res.joint_on;
   assign rsp_position_cmd  = res.position_cmd;
   assign rsp_position_goal = res.position_goal;
   assign rsp_drive_kp      = res.drive_kp;
   assign rsp_drive_kd      = res.drive_kd;
   assign rsp_drive_tau     = res.drive_tau;
   assign rsp_stored_kp     = res.stored_kp;
   assign rsp_stored_kd     = res.stored_kd;
   assign rsp_estop_now     = res.estop_now;
   assign rsp_bad_index     = res.bad_index;

endmodule
